// ----- src/bmhpq_pkg.sv -----
`timescale 1ns / 1ps
package bmhpq_pkg;

  localparam int TAG_BITS  = 8;
  localparam int TAG_COUNT = 256;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_DELETE = 2'd1,
    OP_POP    = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_BADTAG = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]          opcode;
    logic [TAG_BITS-1:0] item_tag;
    logic [31:0]         item_cost;
  } in_item_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [TAG_BITS-1:0] out_tag;
    logic [31:0]         out_cost;
    logic [8:0]          count;
  } out_item_t;

endpackage

// ----- src/bmhpq_ram.sv -----
`timescale 1ns / 1ps
module bmhpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/binary_min_heap_priority_queue_core.sv -----
`timescale 1ns / 1ps
// channel  direction  handshake             payload
// in       input      in_valid / in_ready   in_data   (opcode, item_tag, item_cost)
// out      output     out_valid / out_ready out_data  (status, out_tag, out_cost, count)
//
// one item at a time; in_ready stays low from acceptance until the operation finishes
// add: the new item rises one level at a time while strictly cheaper than its parent
// delete / remove head: when the last entry is the one removed it just leaves, else the last
// entry fills the hole, sinks or rises, paced by the one heap memory read per cycle
// reset (rst_n low, synchronous) empties the queue and marks every tag absent at once
// a result waits in the output register; a second one holds the sequencer in its final state
module binary_min_heap_priority_queue_core
  import bmhpq_pkg::*;
#(
  parameter int CAPACITY  = 256,
  parameter int COST_BITS = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  // stored cost width: only the low bits of the 32-bit field survive
  localparam int CW   = (COST_BITS < 32) ? COST_BITS : 32;
  localparam int PW   = $clog2(CAPACITY);
  localparam int CNTW = $clog2(CAPACITY + 1);
  localparam int CIW  = PW + 2;

  typedef struct packed {
    logic [TAG_BITS-1:0] tag;
    logic [CW-1:0]       cost;
  } entry_t;

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_LOOK = 11'b00000000010,
    S_HEAD = 11'b00000000100,
    S_RM   = 11'b00000001000,
    S_RML  = 11'b00000010000,
    S_DL   = 11'b00000100000,
    S_DR   = 11'b00001000000,
    S_DC   = 11'b00010000000,
    S_UP   = 11'b00100000000,
    S_UPW  = 11'b01000000000,
    S_FIN  = 11'b10000000000
  } state_t;

  state_t              state_r, state_nxt;
  logic [PW-1:0]       pos_r, pos_nxt;
  entry_t              cur_r, cur_nxt;
  entry_t              lft_r, lft_nxt;
  logic [CNTW-1:0]     cnt_r, cnt_nxt;
  logic [TAG_BITS-1:0] tag_r, tag_nxt;
  status_t             status_r, status_nxt;
  logic [TAG_BITS-1:0] otag_r, otag_nxt;
  logic [CW-1:0]       ocost_r, ocost_nxt;
  logic                out_valid_r;
  out_item_t           out_r;
  logic [TAG_COUNT-1:0] present_r;

  // memory ports
  logic                hp_we;
  logic [PW-1:0]       hp_waddr, hp_raddr;
  entry_t              hp_wdata, hp_rdata;
  logic                tp_we;
  logic [TAG_BITS-1:0] tp_waddr, tp_raddr;
  logic [PW-1:0]       tp_wdata, tp_rdata;

  logic                tag_set, tag_clr;
  logic [TAG_BITS-1:0] set_tag;

  logic                accept;
  logic [CIW-1:0]      lidx, ridx, cnt_ext, pos_ext;
  logic [PW-1:0]       parent;
  logic [CNTW-1:0]     last;
  logic                r_ok, take_l, take_r;
  logic [CW-1:0]       best_cost;
  logic [CNTW+8:0]     cnt_wide;
  logic [CW+31:0]      cost_wide;

  bmhpq_ram #(.WIDTH($bits(entry_t)), .DEPTH(CAPACITY)) u_heap (
    .clk   (clk),
    .we    (hp_we),
    .waddr (hp_waddr),
    .wdata (hp_wdata),
    .raddr (hp_raddr),
    .rdata (hp_rdata)
  );

  // tag to position map; presence lives in flops so reset clears it at once
  bmhpq_ram #(.WIDTH(PW), .DEPTH(TAG_COUNT)) u_tagpos (
    .clk   (clk),
    .we    (tp_we),
    .waddr (tp_waddr),
    .wdata (tp_wdata),
    .raddr (tp_raddr),
    .rdata (tp_rdata)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // tree index arithmetic
  assign lidx    = {1'b0, pos_r, 1'b1};
  assign ridx    = lidx + CIW'(1);
  assign cnt_ext = CIW'(cnt_r);
  assign pos_ext = CIW'(pos_r);
  assign parent  = PW'((pos_r - PW'(1)) >> 1);
  assign last    = cnt_r - CNTW'(1);

  // sift-down compare: left wins ties, child must be strictly cheaper
  assign r_ok      = ridx < cnt_ext;
  assign take_l    = lft_r.cost < cur_r.cost;
  assign best_cost = take_l ? lft_r.cost : cur_r.cost;
  assign take_r    = r_ok && (hp_rdata.cost < best_cost);

  always_comb begin
    state_nxt  = state_r;
    pos_nxt    = pos_r;
    cur_nxt    = cur_r;
    lft_nxt    = lft_r;
    cnt_nxt    = cnt_r;
    tag_nxt    = tag_r;
    status_nxt = status_r;
    otag_nxt   = otag_r;
    ocost_nxt  = ocost_r;
    hp_we      = 1'b0;
    hp_waddr   = pos_r;
    hp_wdata   = cur_r;
    hp_raddr   = '0;
    tp_we      = 1'b0;
    tp_waddr   = cur_r.tag;
    tp_wdata   = pos_r;
    tp_raddr   = in_data.item_tag;
    tag_set    = 1'b0;
    tag_clr    = 1'b0;
    set_tag    = in_data.item_tag;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          tag_nxt    = in_data.item_tag;
          status_nxt = ST_OK;
          otag_nxt   = '0;
          ocost_nxt  = '0;
          case (in_data.opcode)
            OP_ADD: begin
              if (cnt_r >= CNTW'(CAPACITY)) begin
                status_nxt = ST_FULL;
                state_nxt  = S_FIN;
              end else if (present_r[in_data.item_tag]) begin
                status_nxt = ST_BADTAG;
                state_nxt  = S_FIN;
              end else begin
                tag_set   = 1'b1;
                cur_nxt   = '{tag: in_data.item_tag, cost: in_data.item_cost[CW-1:0]};
                pos_nxt   = PW'(cnt_r);
                cnt_nxt   = cnt_r + CNTW'(1);
                state_nxt = S_UP;
              end
            end
            OP_DELETE: begin
              if (cnt_r == '0) begin
                status_nxt = ST_EMPTY;
                state_nxt  = S_FIN;
              end else begin
                state_nxt = S_LOOK;
              end
            end
            OP_POP: begin
              if (cnt_r == '0) begin
                status_nxt = ST_EMPTY;
                state_nxt  = S_FIN;
              end else begin
                hp_raddr  = '0;
                state_nxt = S_HEAD;
              end
            end
            default: begin
              state_nxt = S_FIN;
            end
          endcase
        end
      end
      S_LOOK: begin
        if (!present_r[tag_r]) begin
          status_nxt = ST_BADTAG;
          state_nxt  = S_FIN;
        end else begin
          pos_nxt   = tp_rdata;
          state_nxt = S_RM;
        end
      end
      S_HEAD: begin
        otag_nxt  = hp_rdata.tag;
        ocost_nxt = hp_rdata.cost;
        tag_nxt   = hp_rdata.tag;
        pos_nxt   = '0;
        state_nxt = S_RM;
      end
      S_RM: begin
        // drop the removed tag, pull the last entry into the hole
        tag_clr  = 1'b1;
        cnt_nxt  = last;
        hp_raddr = PW'(last);
        if (CNTW'(pos_r) == last) begin
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_RML;
        end
      end
      S_RML: begin
        cur_nxt   = hp_rdata;
        state_nxt = S_DL;
      end
      S_DL: begin
        if (lidx < cnt_ext) begin
          hp_raddr  = lidx[PW-1:0];
          state_nxt = S_DR;
        end else begin
          state_nxt = S_UP;
        end
      end
      S_DR: begin
        lft_nxt   = hp_rdata;
        hp_raddr  = ridx[PW-1:0];
        state_nxt = S_DC;
      end
      S_DC: begin
        if (take_r) begin
          hp_we     = 1'b1;
          hp_wdata  = hp_rdata;
          tp_we     = 1'b1;
          tp_waddr  = hp_rdata.tag;
          pos_nxt   = ridx[PW-1:0];
          state_nxt = S_DL;
        end else if (take_l) begin
          hp_we     = 1'b1;
          hp_wdata  = lft_r;
          tp_we     = 1'b1;
          tp_waddr  = lft_r.tag;
          pos_nxt   = lidx[PW-1:0];
          state_nxt = S_DL;
        end else begin
          state_nxt = S_UP;
        end
      end
      S_UP: begin
        if (pos_ext == '0) begin
          hp_we     = 1'b1;
          tp_we     = 1'b1;
          state_nxt = S_FIN;
        end else begin
          hp_raddr  = parent;
          state_nxt = S_UPW;
        end
      end
      S_UPW: begin
        // parent moves down into the hole while the item is strictly cheaper
        hp_we = 1'b1;
        tp_we = 1'b1;
        if (cur_r.cost < hp_rdata.cost) begin
          hp_wdata  = hp_rdata;
          tp_waddr  = hp_rdata.tag;
          pos_nxt   = parent;
          state_nxt = S_UP;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign cnt_wide  = {9'd0, cnt_r};
  assign cost_wide = {32'd0, ocost_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      present_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (tag_set) begin
        present_r[set_tag] <= 1'b1;
      end
      if (tag_clr) begin
        present_r[tag_r] <= 1'b0;
      end
      if (state_r == S_FIN && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos_r    <= pos_nxt;
    cur_r    <= cur_nxt;
    lft_r    <= lft_nxt;
    tag_r    <= tag_nxt;
    status_r <= status_nxt;
    otag_r   <= otag_nxt;
    ocost_r  <= ocost_nxt;
    if (state_r == S_FIN && (!out_valid_r || out_ready)) begin
      out_r.status   <= status_r;
      out_r.out_tag  <= otag_r;
      out_r.out_cost <= cost_wide[31:0];
      out_r.count    <= cnt_wide[8:0];
    end
  end

endmodule
